/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_CLK_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_CLK_NR(label, clk, prop, msg)
`endif
`endif

/* rtl/hecs_pkg.sv */
package hecs_pkg;
  localparam int MaxDim = 4096;
  localparam int MaxEllWidth = 64;
  localparam int IdxW = $clog2(MaxDim);
  localparam int YW = 48;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_ELL  = 2'd1;
  localparam logic [1:0] REQ_COO  = 2'd2;
  localparam logic [1:0] REQ_READ = 2'd3;

  localparam logic [1:0] CFG_ROWS = 2'd0;
  localparam logic [1:0] CFG_WIDTH = 2'd1;
  localparam logic [1:0] CFG_SKIP = 2'd2;

  localparam logic signed [YW-1:0] YMax = {1'b0, {(YW-1){1'b1}}};
  localparam logic signed [YW-1:0] YMin = {1'b1, {(YW-1){1'b0}}};

  typedef struct packed {
    logic [1:0] req_type;
    logic [11:0] req_row;
    logic [11:0] column;
    logic pad_marker;
    logic signed [31:0] entry_value;
  } req_t;

  typedef struct packed {
    logic [11:0] out_row;
    logic signed [47:0] y_value;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLEAR, ST_RD, ST_MUL, ST_ACC
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic clear_wr;
    logic capture;
    logic rd_mem;
    logic mul;
    logic acc;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clear_done;
    logic is_accum;
  } sts_t;
endpackage

/* rtl/hybrid_ell_coo_spmv.sv */
// A read's result strobe is high in the cycle after its store read.
// A load or a read passes through the read state only; an accumulating ELL or
// COO entry goes on through the multiply and accumulate states. The x read,
// the registered multiply and the y read-modify-write run on one item at a time.
// Reset: synchronous; afterwards a clearing pass zeroes the y store, with busy
// high. The receiver cannot stall: each result is shown for one cycle.
module hybrid_ell_coo_spmv import hecs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  input  logic cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [12:0] cfg_data,
  output logic strobe,
  output rsp_t result
);
  // The controller sequences each item; the datapath owns stores and counters.
  cmd_t cmd;
  sts_t sts;

  hecs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .sts(sts), .cmd(cmd), .busy(busy)
  );

  hecs_dp u_dp (
    .clk(clk), .rst(rst), .req(req), .cmd(cmd), .cfg_we(cfg_we),
    .cfg_idx(cfg_idx), .cfg_data(cfg_data), .sts(sts),
    .strobe(strobe), .result(result)
  );
endmodule

/* rtl/hecs_ctrl.sv */
`include "assert_macros.svh"
module hecs_ctrl import hecs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (sts.clear_done) state_next = ST_IDLE;
      ST_IDLE:  if (start) state_next = ST_RD;
      ST_RD: begin
        if (sts.is_accum) state_next = ST_MUL;
        else state_next = ST_IDLE;
      end
      ST_MUL: state_next = ST_ACC;
      ST_ACC: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    unique case (state)
      ST_CLEAR: cmd.clear_wr = 1'b1;
      ST_IDLE: begin
        busy = 1'b0;
        cmd.capture = start;
      end
      ST_RD: cmd.rd_mem = 1'b1;
      ST_MUL: cmd.mul = 1'b1;
      ST_ACC: cmd.acc = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  `ASSERT_CLK(a_mul_follows_rd, clk, rst, (state == ST_MUL) |-> $past(state == ST_RD), "mul without read")
  `ASSERT_CLK(a_acc_follows_mul, clk, rst, (state == ST_ACC) |-> $past(state == ST_MUL), "acc without mul")
  `ASSERT_CLK(a_capture_idle, clk, rst, cmd.capture |-> !busy, "capture while busy")
endmodule

/* rtl/hecs_dp.sv */
`include "assert_macros.svh"
module hecs_dp import hecs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  cmd_t cmd,
  input  logic cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [12:0] cfg_data,
  output sts_t sts,
  output logic strobe,
  output rsp_t result
);
  logic signed [31:0] x_mem [MaxDim];
  logic signed [YW-1:0] y_mem [MaxDim];

  logic [12:0] row_count;
  logic [6:0] ell_width;
  logic skip_padding;
  logic [IdxW-1:0] ell_row;
  logic [6:0] ell_slot;
  logic row_skipping;
  logic [IdxW:0] clr_cnt;

  req_t cur;
  logic [IdxW-1:0] tgt_row;
  logic do_acc, do_read;
  logic signed [31:0] x_rd;
  logic signed [YW-1:0] y_rd;
  logic signed [63:0] prod;
  logic signed [YW:0] sum_ext;
  logic signed [YW-1:0] sat_sum;

  logic [12:0] eff_rows;
  logic [6:0] eff_w;
  logic [12:0] row_base, row_inc;
  logic [6:0] slot_inc;
  logic skip_now;

  assign eff_rows = (row_count == 13'd0 || row_count > 13'(MaxDim)) ? 13'(MaxDim) : row_count;
  assign eff_w = (ell_width > 7'(MaxEllWidth)) ? 7'(MaxEllWidth) : ell_width;
  assign row_base = ({1'b0, ell_row} >= eff_rows) ? 13'd0 : {1'b0, ell_row};
  assign row_inc = row_base + 13'd1;
  assign slot_inc = ell_slot + 7'd1;
  assign skip_now = skip_padding && (row_skipping || req.pad_marker);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= 13'(MaxDim);
      ell_width <= '0;
      skip_padding <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ROWS: row_count <= cfg_data;
        CFG_WIDTH: ell_width <= cfg_data[6:0];
        CFG_SKIP: skip_padding <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Item capture and ELL counter update.
  always_ff @(posedge clk) begin
    if (rst) begin
      ell_row <= '0;
      ell_slot <= '0;
      row_skipping <= 1'b0;
      do_acc <= 1'b0;
      do_read <= 1'b0;
    end else if (cmd.capture) begin
      cur <= req;
      do_acc <= 1'b0;
      do_read <= 1'b0;
      unique case (req.req_type)
        REQ_LOAD: ;
        REQ_COO: begin
          tgt_row <= req.req_row;
          do_acc <= 1'b1;
        end
        REQ_READ: begin
          tgt_row <= req.req_row;
          do_read <= 1'b1;
        end
        REQ_ELL: begin
          if (eff_w != 7'd0) begin
            tgt_row <= row_base[IdxW-1:0];
            do_acc <= !skip_now;
            if (slot_inc >= eff_w) begin
              ell_slot <= '0;
              row_skipping <= 1'b0;
              ell_row <= (row_inc >= eff_rows) ? '0 : row_inc[IdxW-1:0];
            end else begin
              ell_slot <= slot_inc;
              // The skip flag holds until the row ends, even if skip mode is left.
              row_skipping <= row_skipping || (skip_padding && req.pad_marker);
              ell_row <= row_base[IdxW-1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Clearing pass counter for the y store.
  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clear_wr && !clr_cnt[IdxW]) clr_cnt <= clr_cnt + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture && req.req_type == REQ_LOAD) x_mem[req.column] <= req.entry_value;
    if (cmd.rd_mem) x_rd <= x_mem[cur.column];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_wr && !clr_cnt[IdxW]) y_mem[clr_cnt[IdxW-1:0]] <= '0;
    else if (cmd.rd_mem && do_read) y_mem[tgt_row] <= '0;
    else if (cmd.acc) y_mem[tgt_row] <= sat_sum;
    if (cmd.rd_mem) y_rd <= y_mem[tgt_row];
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) prod <= 64'(cur.entry_value) * 64'(x_rd);
  end

  always_comb begin
    sum_ext = {y_rd[YW-1], y_rd} + (YW+1)'(prod >>> 16);
    if (sum_ext > (YW+1)'(YMax)) sat_sum = YMax;
    else if (sum_ext < (YW+1)'(YMin)) sat_sum = YMin;
    else sat_sum = sum_ext[YW-1:0];
  end

  logic rd_d;
  always_ff @(posedge clk) begin
    if (rst) rd_d <= 1'b0;
    else rd_d <= cmd.rd_mem && do_read;
  end
  assign strobe = rd_d;
  assign result.out_row = cur.req_row;
  assign result.y_value = y_rd;

  assign sts.clear_done = clr_cnt[IdxW];
  assign sts.is_accum = do_acc;

  `ASSERT_CLK(a_no_acc_and_read, clk, rst, !(do_acc && do_read), "accumulate and read together")
  `ASSERT_CLK(a_strobe_after_read, clk, rst, strobe |-> $past(cmd.rd_mem), "strobe without read")
  `ASSERT_CLK(a_slot_in_range, clk, rst, ell_slot <= 7'(MaxEllWidth), "slot counter out of range")
endmodule

/* tb/hybrid_ell_coo_spmv_tb.sv */
`timescale 1ns / 1ps

// Self-checking bench for the hybrid ELL plus COO sparse matrix-vector block.
// Items are queued by the stimulus process and sent by a falling-edge driver
// that works in bursts with random gaps. Every accepted item also goes through
// a local predictor of the y store and the ELL counters. A read item pushes its
// expected row sum, and the monitor checks each strobed result against the
// oldest expectation.
module hybrid_ell_coo_spmv_tb;
  import hecs_pkg::*;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic cfg_we;
  logic [1:0] cfg_idx;
  logic [12:0] cfg_data;
  logic strobe;
  rsp_t result;

  hybrid_ell_coo_spmv dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .strobe(strobe), .result(result)
  );

  // Local copy of the block's state and registers.
  logic signed [31:0] x_mem [MaxDim];
  bit x_loaded [MaxDim];
  logic signed [47:0] y_mem [MaxDim];
  logic [11:0] ell_row;
  logic [6:0] ell_slot;
  bit skipping;
  logic [12:0] rows_reg;
  logic [6:0] width_reg;
  bit skip_reg;

  req_t pending_items[$];
  rsp_t expected_sums[$];
  int errors;
  longint cycles;
  int burst_left;
  int gap_left;
  bit idle_free;
  logic busy_at_rise;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Cycle counter with a generous limit: the clearing pass, every item's
  // states and the longest gaps, several times over.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("status: fail");
      $finish;
    end
  end

  // The product is cut toward minus infinity, then added with saturation.
  function automatic logic signed [47:0] sat_add(logic signed [47:0] acc,
                                                  logic signed [31:0] a,
                                                  logic signed [31:0] b);
    logic signed [63:0] prod;
    logic signed [49:0] sum;
    prod = 64'(a) * 64'(b);
    sum = 50'(acc) + 50'(prod >>> 16);
    if (sum > YMax) return YMax;
    if (sum < YMin) return YMin;
    return sum[47:0];
  endfunction

  // Advance the predictor by one accepted item.
  task automatic predict_item(req_t it);
    int w;
    int nrows;
    rsp_t exp_rsp;
    w = (width_reg > 7'(MaxEllWidth)) ? MaxEllWidth : int'(width_reg);
    nrows = (rows_reg == 13'd0 || rows_reg > 13'(MaxDim)) ? MaxDim : int'(rows_reg);
    case (it.req_type)
      REQ_LOAD: begin
        x_mem[it.column] = it.entry_value;
      end
      REQ_ELL: begin
        if (w != 0) begin
          if (ell_row >= nrows) ell_row = '0;
          if (skip_reg && it.pad_marker) skipping = 1;
          if (!(skip_reg && skipping))
            y_mem[ell_row] = sat_add(y_mem[ell_row], it.entry_value, x_mem[it.column]);
          ell_slot = ell_slot + 7'd1;
          if (ell_slot >= w) begin
            ell_slot = '0;
            skipping = 0;
            ell_row = ell_row + 12'd1;
            if (ell_row >= nrows) ell_row = '0;
          end
        end
      end
      REQ_COO: begin
        y_mem[it.req_row] = sat_add(y_mem[it.req_row], it.entry_value,
                                    x_mem[it.column]);
      end
      default: begin
        exp_rsp.out_row = it.req_row;
        exp_rsp.y_value = y_mem[it.req_row];
        y_mem[it.req_row] = '0;
        expected_sums.push_back(exp_rsp);
      end
    endcase
  endtask

  // Driver: items change at the falling edge. An item is taken at a rising
  // edge with start high and busy low, so start is held until that happens.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy_at_rise) begin
        // Accepted at the last rising edge: choose what to show next.
        if (pending_items.size() != 0 && gap_left == 0 && burst_left > 0) begin
          req <= pending_items.pop_front();
          burst_left <= burst_left - 1;
        end else begin
          start <= 1'b0;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= idle_free ? 0 : $urandom_range(0, 6);
          end
        end
      end else if (!start) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_items.size() != 0) begin
          req <= pending_items.pop_front();
          start <= 1'b1;
          if (burst_left > 0) burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Acceptance is detected at the rising edge; the predictor runs there too,
  // on the item that the block has just taken.
  always @(posedge clk) begin
    busy_at_rise <= busy;
    if (!rst && start && !busy) begin
      predict_item(req);
    end
  end

  // Monitor: each strobe is compared with the oldest expected row sum.
  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (!rst && strobe) begin
      if (expected_sums.size() == 0) begin
        $display("%0t: unexpected result, actual row %0d y %0d", $time,
                 result.out_row, result.y_value);
        errors = errors + 1;
      end else begin
        exp_rsp = expected_sums.pop_front();
        if (result.out_row !== exp_rsp.out_row) begin
          $display("%0t: out_row expected %0d actual %0d", $time,
                   exp_rsp.out_row, result.out_row);
          errors = errors + 1;
        end
        if (result.y_value !== exp_rsp.y_value) begin
          $display("%0t: y_value expected %0d actual %0d", $time,
                   exp_rsp.y_value, result.y_value);
          errors = errors + 1;
        end
      end
    end
  end

  // Picks a random column; only columns that were loaded may be used by
  // entries, since unwritten x elements are outside the contract.
  function automatic logic [11:0] loaded_col(logic [11:0] lo, logic [11:0] hi);
    logic [11:0] c;
    c = 12'($urandom_range(lo, hi));
    while (!x_loaded[c]) c = 12'($urandom_range(lo, hi));
    return c;
  endfunction

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $urandom_range(0, 32'h3FFFF) - 32'sh20000;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_item(logic [1:0] kind, logic [11:0] row, logic [11:0] col,
                            logic pad, logic signed [31:0] val);
    req_t it;
    it.req_type = kind;
    it.req_row = row;
    it.column = col;
    it.pad_marker = pad;
    it.entry_value = val;
    if (kind == REQ_LOAD) x_loaded[col] = 1;
    pending_items.push_back(it);
  endtask

  // Waits until every item has gone and every result has come, then for the
  // block's longest item time so that the last entry has been written back.
  task automatic drain();
    while (pending_items.size() != 0 || start || busy || expected_sums.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ROWS: rows_reg = value;
      CFG_WIDTH: width_reg = value[6:0];
      default: skip_reg = value[0];
    endcase
  endtask

  // One phase of random traffic over a small set of rows and columns so that
  // reads find real sums. ELL entries come in runs, whole rows up to a width of eight.
  task automatic random_phase(int count);
    logic [11:0] lo;
    logic [11:0] hi;
    int n;
    int w;
    int k;
    lo = 12'($urandom_range(0, 4000));
    hi = lo + 12'd15;
    for (k = 0; k < 16; k++)
      queue_item(REQ_LOAD, 12'($urandom), 12'(lo + k), 1'($urandom), rand_value());
    n = 16;
    w = (width_reg > 7'(MaxEllWidth)) ? MaxEllWidth : int'(width_reg);
    while (n < count) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          for (k = 0; k < w && k < 8; k++) begin
            queue_item(REQ_ELL, 12'($urandom), loaded_col(lo, hi),
                       ($urandom_range(0, 5) == 0), rand_value());
            n++;
          end
          if (w == 0) begin
            queue_item(REQ_ELL, 12'($urandom), loaded_col(lo, hi), 1'($urandom),
                       rand_value());
          end
        end
        3, 4: begin
          queue_item(REQ_COO, 12'($urandom_range(0, 7)), loaded_col(lo, hi), 1'($urandom),
                     rand_value());
          n++;
        end
        5: begin
          queue_item(REQ_COO, 12'($urandom), loaded_col(lo, hi), 1'($urandom),
                     rand_value());
          n++;
        end
        6: begin
          queue_item(REQ_LOAD, 12'($urandom), 12'(lo + $urandom_range(0, 15)),
                     1'($urandom), rand_value());
          n++;
        end
        default: begin
          queue_item(REQ_READ,
                     12'($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom),
                     12'($urandom), 1'($urandom), $urandom);
          n++;
        end
      endcase
    end
  endtask

  initial begin
    int ph;
    errors = 0;
    cycles = 0;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_idx = CFG_ROWS;
    cfg_data = '0;
    burst_left = 4;
    gap_left = 0;
    idle_free = 0;
    rows_reg = 13'd4096;
    width_reg = '0;
    skip_reg = 0;
    ell_row = '0;
    ell_slot = '0;
    skipping = 0;
    for (int i = 0; i < MaxDim; i++) begin
      y_mem[i] = '0;
      x_mem[i] = '0;
      x_loaded[i] = 0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part with the reset settings: zero ELL width ignores ELL items.
    queue_item(REQ_LOAD, 12'd0, 12'd0, 1'b0, 32'sh7FFFFFFF);
    queue_item(REQ_LOAD, 12'hFFF, 12'hFFF, 1'b1, 32'sh80000000);
    queue_item(REQ_LOAD, 12'd0, 12'd1, 1'b0, 32'sh00010000);
    queue_item(REQ_ELL, 12'd0, 12'd0, 1'b0, 32'sh7FFFFFFF);
    queue_item(REQ_COO, 12'hFFF, 12'hFFF, 1'b1, 32'sh80000000);
    queue_item(REQ_COO, 12'hFFF, 12'hFFF, 1'b0, 32'sh80000000);
    queue_item(REQ_READ, 12'hFFF, 12'hFFF, 1'b1, 32'shFFFFFFFF);
    queue_item(REQ_READ, 12'd0, 12'd0, 1'b0, 32'sh0);
    // Positive and negative saturation of row 5.
    for (int i = 0; i < 4; i++) queue_item(REQ_COO, 12'd5, 12'd0, 1'b0, 32'sh7FFFFFFF);
    queue_item(REQ_READ, 12'd5, 12'd0, 1'b0, 32'sh0);
    for (int i = 0; i < 4; i++) queue_item(REQ_COO, 12'd5, 12'd0, 1'b0, 32'sh80000000);
    queue_item(REQ_READ, 12'd5, 12'd0, 1'b0, 32'sh0);
    queue_item(REQ_COO, 12'd6, 12'd1, 1'b0, -32'sd3);
    queue_item(REQ_READ, 12'd6, 12'd0, 1'b0, 32'sh0);
    drain();

    // Width above the maximum, two rows, skip mode with a pad marker.
    write_reg(CFG_ROWS, 13'd2);
    write_reg(CFG_WIDTH, 13'd127);
    write_reg(CFG_SKIP, 13'd1);
    queue_item(REQ_ELL, 12'd0, 12'd1, 1'b0, 32'sh00020000);
    queue_item(REQ_ELL, 12'd0, 12'd1, 1'b1, 32'sh00030000);
    queue_item(REQ_ELL, 12'd0, 12'd1, 1'b0, 32'sh00040000);
    queue_item(REQ_READ, 12'd0, 12'd0, 1'b0, 32'sh0);
    drain();

    // Shrinking the registers mid-row leaves the slot counter beyond the width.
    write_reg(CFG_ROWS, 13'd1);
    write_reg(CFG_WIDTH, 13'd1);
    write_reg(CFG_SKIP, 13'd0);
    queue_item(REQ_ELL, 12'd0, 12'd1, 1'b1, 32'sh00010000);
    queue_item(REQ_ELL, 12'd0, 12'd1, 1'b0, 32'sh00010000);
    queue_item(REQ_READ, 12'd0, 12'd0, 1'b0, 32'sh0);
    drain();
    write_reg(CFG_ROWS, 13'd0);
    drain();

    // Random phases over several settings, the extremes among them.
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(CFG_ROWS, 13'd4096); write_reg(CFG_WIDTH, 13'd64); end
        1: begin write_reg(CFG_ROWS, 13'd8191); write_reg(CFG_WIDTH, 13'd3); end
        2: begin write_reg(CFG_ROWS, 13'd1); write_reg(CFG_WIDTH, 13'd0); end
        default: begin
          write_reg(CFG_ROWS, 13'($urandom_range(1, 8)));
          write_reg(CFG_WIDTH, 13'($urandom_range(1, 6)));
        end
      endcase
      write_reg(CFG_SKIP, 13'($urandom_range(0, 1)));
      idle_free = (ph == 4);
      random_phase(110);
      drain();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

/* sim.f */
+incdir+rtl
rtl/hecs_pkg.sv
rtl/hecs_ctrl.sv
rtl/hecs_dp.sv
rtl/hybrid_ell_coo_spmv.sv
tb/hybrid_ell_coo_spmv_tb.sv
